>>> rtl/sidsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidsu_pkg
// Shared types and constants of the sensor ID table supervision unit.
// ----------------------------------------------------------------------------
package sidsu_pkg;

   localparam int ENTRIES   = 16;
   localparam int ZONE_BASE = 3;
   localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ID_W      = 48;
   localparam int ZONE_W    = 5;
   localparam int CNT_W     = 8;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      KIND_LOOKUP  = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_DELETE  = 3'd2,
      KIND_TICK    = 3'd3,
      KIND_REPORT  = 3'd4,
      KIND_CHECKIN = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_FAULT = 2'd1,
      EV_BATT  = 2'd2
   } event_type_type;

   typedef enum logic [0:0] {
      REG_LIMIT = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]      kind;
      logic [ID_W-1:0] device_id;
      logic [7:0]      zone_number;
      logic            battery_low;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [ZONE_W-1:0] zone_out;
      logic [1:0]        event_type;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic             low_batt;
      logic [CNT_W-1:0] count;
      logic             fault;
   } entry_type;

   // Read and write controls toward the entry table.
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
   } table_ctl_type;

endpackage

>>> rtl/sensor_id_table_supervision_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_id_table_supervision_unit
// Table of sensor IDs with lookup, add, delete, supervision tick, fault
// report and check-in. Entries live in a memory with registered read data,
// scanned one slot per cycle unless held; occupancy bits live in flip-flops.
//
//   channel  ports                         direction  payload
//   req      req_valid/req_stall/req_data  in         req_type
//   rsp      rsp_valid/rsp_stall/rsp_data  out        rsp_type
//   csr      psel/penable/pwrite/paddr...  in/out     supervision_limit
//
// Add, delete and unknown kinds pass from the transfer through the done
// state into the output register. Lookup, check-in, tick and report scan
// the memory one slot per cycle unless stalled, stopping early when a
// lookup or check-in matches; a report visits an occupied slot with a fault
// mark twice. The single read port sets this rate. Results stall the scan
// only when a new result meets a full pending result and a stalled output
// register. Reset empties the table at once.
// ----------------------------------------------------------------------------
module sensor_id_table_supervision_unit
   import sidsu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              phase_ff, phase_in;
   logic [2:0]        kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              batt_ff, batt_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           pend_ff, pend_in;
   logic              dflt_status_ff, dflt_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;

   table_ctl_type     tctl;
   entry_type         rd_entry;

   logic              accept;
   logic              out_free;
   logic              out_push;
   rsp_type           out_data;

   logic              cur_valid;
   logic              id_match;
   logic              tick_go;
   logic              tick_reach;
   logic [CNT_W-1:0]  cnt_next;
   logic [ZONE_W-1:0] cur_zone;
   logic              emit;
   logic [1:0]        emit_ev;
   logic              stop;
   logic              hold_slot;
   logic              blocked;
   logic              step;
   logic              advance;
   logic              scan_end;

   logic              free_any;
   logic [SLOT_W-1:0] free_slot;
   logic              del_ok;
   logic [SLOT_W-1:0] del_slot;
   logic              csr_wr;

   sidsu_table u_table (
      .clock   (clock),
      .ctl     (tctl),
      .rd_data (rd_entry)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr && (paddr[ADDR_W-1] == REG_LIMIT)) begin
         limit_in = pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[ADDR_W-1] == REG_LIMIT) begin
         prdata = DATA_W'(limit_ff);
      end
   end

   // First free slot and delete decode
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int s = ENTRIES - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(s);
         end
      end
   end

   assign del_ok   = (req_data.zone_number >= 8'(ZONE_BASE)) &&
                     (req_data.zone_number < 8'(ZONE_BASE + ENTRIES));
   assign del_slot = SLOT_W'(req_data.zone_number - 8'(ZONE_BASE));

   // Per-slot evaluation during a scan
   assign cur_valid  = valid_ff[cur_ff];
   assign id_match   = cur_valid && (rd_entry.id == id_ff);
   assign cnt_next   = rd_entry.count + CNT_W'(1);
   assign tick_go    = cur_valid && (rd_entry.count < limit_ff);
   assign tick_reach = tick_go && (cnt_next >= limit_ff);
   assign cur_zone   = ZONE_W'(cur_ff) + ZONE_W'(ZONE_BASE);

   always_comb begin
      emit      = 1'b0;
      emit_ev   = EV_NONE;
      stop      = 1'b0;
      hold_slot = 1'b0;
      case (kind_ff)
         KIND_LOOKUP, KIND_CHECKIN: begin
            emit = id_match;
            stop = id_match;
         end
         KIND_TICK: begin
            emit    = tick_reach;
            emit_ev = EV_FAULT;
         end
         KIND_REPORT: begin
            if (!phase_ff) begin
               emit      = cur_valid && rd_entry.low_batt;
               emit_ev   = EV_BATT;
               hold_slot = cur_valid && rd_entry.fault;
            end else begin
               emit    = 1'b1;
               emit_ev = EV_FAULT;
            end
         end
         default: begin
         end
      endcase
   end

   assign blocked  = emit && pend_valid_ff && !out_free;
   assign step     = (state_ff == ST_SCAN) && !blocked;
   assign advance  = step && !stop && !hold_slot;
   assign scan_end = step && (stop || (advance && (cur_ff == LAST_SLOT)));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_LOOKUP || req_data.kind == KIND_CHECKIN ||
                   req_data.kind == KIND_TICK || req_data.kind == KIND_REPORT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      cur_in         = cur_ff;
      phase_in       = phase_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      batt_in        = batt_ff;
      valid_in       = valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      dflt_status_in = dflt_status_ff;
      tctl           = '0;
      out_push       = 1'b0;
      out_data       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in        = req_data.kind;
               id_in          = req_data.device_id;
               batt_in        = req_data.battery_low;
               cur_in         = '0;
               phase_in       = 1'b0;
               pend_valid_in  = 1'b0;
               dflt_status_in = 1'b0;
               case (req_data.kind)
                  KIND_LOOKUP, KIND_CHECKIN: begin
                     tctl.rd_en     = 1'b1;
                     dflt_status_in = 1'b1;
                  end
                  KIND_TICK, KIND_REPORT: begin
                     tctl.rd_en = 1'b1;
                  end
                  KIND_ADD: begin
                     dflt_status_in = 1'b1;
                     if (free_any) begin
                        tctl.wr_en        = 1'b1;
                        tctl.wr_addr      = free_slot;
                        tctl.wr_data      = '0;
                        tctl.wr_data.id   = req_data.device_id;
                        valid_in[free_slot] = 1'b1;
                        pend_valid_in     = 1'b1;
                        pend_in           = '0;
                        pend_in.zone_out  = ZONE_W'(free_slot) + ZONE_W'(ZONE_BASE);
                     end
                  end
                  KIND_DELETE: begin
                     dflt_status_in = 1'b1;
                     if (del_ok) begin
                        valid_in[del_slot] = 1'b0;
                        pend_valid_in      = 1'b1;
                        pend_in            = '0;
                        pend_in.zone_out   = req_data.zone_number[ZONE_W-1:0];
                     end
                  end
                  default: begin
                     dflt_status_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (step) begin
               if (emit) begin
                  // Push the older result out, keep the new one pending.
                  if (pend_valid_ff) begin
                     out_push      = 1'b1;
                     out_data      = pend_ff;
                     out_data.last = 1'b0;
                  end
                  pend_valid_in      = 1'b1;
                  pend_in            = '0;
                  pend_in.zone_out   = cur_zone;
                  pend_in.event_type = emit_ev;
               end
               if (kind_ff == KIND_CHECKIN && id_match) begin
                  tctl.wr_en            = 1'b1;
                  tctl.wr_addr          = cur_ff;
                  tctl.wr_data          = '0;
                  tctl.wr_data.id       = id_ff;
                  tctl.wr_data.low_batt = batt_ff;
               end
               if (kind_ff == KIND_TICK && tick_go) begin
                  tctl.wr_en         = 1'b1;
                  tctl.wr_addr       = cur_ff;
                  tctl.wr_data       = rd_entry;
                  tctl.wr_data.count = cnt_next;
                  tctl.wr_data.fault = rd_entry.fault || tick_reach;
               end
               if (hold_slot) begin
                  phase_in = 1'b1;
               end
               if (advance) begin
                  phase_in = 1'b0;
                  if (cur_ff != LAST_SLOT) begin
                     cur_in       = cur_ff + SLOT_W'(1);
                     tctl.rd_en   = 1'b1;
                     tctl.rd_addr = cur_ff + SLOT_W'(1);
                  end
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_push = 1'b1;
               if (pend_valid_ff) begin
                  out_data = pend_ff;
               end else begin
                  out_data        = '0;
                  out_data.status = dflt_status_ff;
               end
               out_data.last = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= CNT_W'(84);
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_ff      <= limit_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      batt_ff        <= batt_in;
      pend_ff        <= pend_in;
      dflt_status_ff <= dflt_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Checks
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && rsp_data_ff.last))
      else $error("closing result not marked last");

   a_mid_push_scan: assert property (@(posedge clock) disable iff (reset)
      (out_push && !out_data.last) |-> (state_ff == ST_SCAN))
      else $error("intermediate result outside a scan");

   a_no_write_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && blocked) |-> (!tctl.wr_en && !tctl.rd_en))
      else $error("table access while result path is blocked");

endmodule

>>> rtl/sidsu_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidsu_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sidsu_table
   import sidsu_pkg::*;
(
   input  logic          clock,
   input  table_ctl_type ctl,
   output entry_type     rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   // Hold read data when no read is issued.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
